### rtl/core/sigmoid_activation_unit_top_defines.svh
// Assertion macros for the sigmoid activation unit.
`ifndef SIGMOID_ACTIVATION_UNIT_TOP_DEFINES_SVH
`define SIGMOID_ACTIVATION_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SAU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define SAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sau_pkg.sv
package sau_pkg;

  // Default parameter values
  localparam int FRAC_BITS_DEF     = 12;
  localparam int TABLE_ENTRIES_DEF = 256;

  // Request codes
  localparam logic REQ_FWD = 1'b0;
  localparam logic REQ_BWD = 1'b1;

  // Signed 16-bit result limits
  localparam logic signed [15:0] RES_MAX = 16'sh7fff;
  localparam logic signed [15:0] RES_MIN = 16'sh8000;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] x_value;
    logic signed [15:0] grad_in;
  } sau_in_t;

  typedef struct packed {
    logic signed [15:0] result;
    logic               saturated;
  } sau_out_t;

endpackage

### rtl/core/sau_rom.sv
module sau_rom import sau_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rd_en,
  input  logic [$clog2(TABLE_ENTRIES+1)-1:0]     rd_idx,
  output logic [FRAC_BITS:0]                     rd_lo,
  output logic [FRAC_BITS:0]                     rd_hi
);

  localparam int ONE_W = FRAC_BITS + 1;
  localparam int IDX_W = $clog2(TABLE_ENTRIES + 1);

  // Table step, 8/TABLE_ENTRIES scaled by 2^31
  localparam longint unsigned STEP = (64'd1 << 34) / 64'(TABLE_ENTRIES);

  typedef logic [ONE_W-1:0] rom_t [TABLE_ENTRIES+1];

  // Unsigned quotient by restoring long division, used only at elaboration
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned dvs);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int bi = 63; bi >= 0; bi--) begin
      rem = {rem[62:0], num[bi]};
      if (rem >= dvs) begin
        rem     = rem - dvs;
        quo[bi] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid samples over [0, 8) plus the end point, rounded to FRAC_BITS
  function automatic rom_t build_rom();
    rom_t              tbl;
    longint unsigned   xs;
    longint unsigned   one;
    longint unsigned   term;
    longint unsigned   r;
    longint unsigned   e;
    longint unsigned   den;
    longint            sum;
    xs   = 64'd1 << 31;
    one  = 64'd1 << FRAC_BITS;
    term = xs;
    sum  = longint'(xs);
    // exp(-step) by its Taylor series
    for (int n = 1; n <= 20; n++) begin
      term = div_u64((term * STEP) >> 31, 64'(n));
      if (n % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    r = unsigned'(sum);
    e = xs;
    for (int k = 0; k <= TABLE_ENTRIES; k++) begin
      if (k > 0) e = (e * r + (xs >> 1)) >> 31;
      den    = xs + e;
      tbl[k] = ONE_W'(div_u64(one * xs + (den >> 1), den));
    end
    return tbl;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [ONE_W-1:0] rd_lo_r;
  logic [ONE_W-1:0] rd_hi_r;
  logic [IDX_W-1:0] idx_hi;

  assign idx_hi = rd_idx + IDX_W'(1);

  // Read both neighbouring samples, hold while stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_lo_r <= ROM[rd_idx];
      rd_hi_r <= ROM[idx_hi];
    end
  end

  assign rd_lo = rd_lo_r;
  assign rd_hi = rd_hi_r;

endmodule

### rtl/core/sigmoid_activation_unit_top.sv
// Throughput: one beat per cycle while the output is not stalled.
// Stages, in order: abs/index and first gradient multiply, table read and
// second gradient multiply, interpolation multiply and gradient rounding,
// then final add, negate and saturate.
// Reset clears the stage valid bits only; the table is constant, so the
// unit takes beats from the first cycle after reset.
`include "sigmoid_activation_unit_top_defines.svh"

module sigmoid_activation_unit_top import sau_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sau_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sau_out_t out_payload
);

  localparam int ONE_W = FRAC_BITS + 1;
  localparam int SH    = FRAC_BITS + 3;
  localparam int IDX_W = $clog2(TABLE_ENTRIES + 1);
  localparam int P_W   = SH + IDX_W;
  localparam int A_W   = 17;
  localparam int CMP_W = (SH + 1 > A_W) ? SH + 1 : A_W;
  localparam int OM_W  = ((FRAC_BITS + 2 > 17) ? FRAC_BITS + 2 : 17) + 1;
  localparam int PR_W  = 32 + OM_W;
  localparam int DP_W  = ONE_W + SH;
  localparam int RSH   = 2 * FRAC_BITS;
  localparam int Q_W   = PR_W - RSH;
  localparam int QX_W  = (Q_W > 17) ? Q_W : 17;
  localparam int SW    = (ONE_W > 16) ? ONE_W : 16;

  localparam logic [ONE_W-1:0]       ONE_V     = ONE_W'(1) << FRAC_BITS;
  localparam logic [CMP_W-1:0]       SPAN_C    = CMP_W'(1) << SH;
  localparam logic [DP_W:0]          HALF_SPAN = (DP_W + 1)'(1) << (SH - 1);
  localparam logic [P_W-1:0]         TE_P      = P_W'(TABLE_ENTRIES);
  localparam logic signed [OM_W-1:0] ONE_OM    = OM_W'(1) << FRAC_BITS;
  localparam logic [PR_W-1:0]        RND_B     = PR_W'(1) << (RSH - 1);
  localparam logic [QX_W-1:0]        POS_MAX   = QX_W'(32767);
  localparam logic [QX_W-1:0]        NEG_MAX   = QX_W'(32768);
  localparam logic [SW-1:0]          FWD_MAX   = SW'(32767);

  // Stage advance: a stage loads when empty or when the next one loads
  logic adv1, adv2, adv3, adv4;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;

  assign adv4     = !s4_v_r || !out_stall;
  assign adv3     = !s3_v_r || adv4;
  assign adv2     = !s2_v_r || adv3;
  assign adv1     = !s1_v_r || adv2;
  assign in_stall = !adv1;

  // Move valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= in_valid;
      if (adv2) s2_v_r <= s1_v_r;
      if (adv3) s3_v_r <= s2_v_r;
      if (adv4) s4_v_r <= s3_v_r;
    end
  end

  // ---------------- Stage 1: magnitude, table index, g*x ----------------
  logic                     x_neg;
  logic [A_W-1:0]           x_abs;
  logic [P_W-1:0]           pos_scaled;
  logic                     s1_req_r, s1_neg_r, s1_clamp_r;
  logic                     s1_clamp_nxt;
  logic [IDX_W-1:0]         s1_idx_r;
  logic [SH-1:0]            s1_frac_r;
  logic signed [31:0]       s1_gx_r, s1_gx_nxt;
  logic signed [OM_W-1:0]   s1_om_r, s1_om_nxt;

  assign x_neg        = in_data.x_value[15];
  assign x_abs        = x_neg ? (A_W'(0) - A_W'(in_data.x_value)) : A_W'(in_data.x_value);
  assign s1_clamp_nxt = CMP_W'(x_abs) >= SPAN_C;
  assign pos_scaled   = P_W'(x_abs) * TE_P;
  assign s1_gx_nxt    = 32'(in_data.grad_in) * 32'(in_data.x_value);
  assign s1_om_nxt    = ONE_OM - OM_W'(in_data.x_value);

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_req_r   <= in_data.req_type;
      s1_neg_r   <= x_neg;
      s1_clamp_r <= s1_clamp_nxt;
      s1_idx_r   <= pos_scaled[P_W-1:SH];
      s1_frac_r  <= pos_scaled[SH-1:0];
      s1_gx_r    <= s1_gx_nxt;
      s1_om_r    <= s1_om_nxt;
    end
  end

  // ---------------- Stage 2: table read, g*x*(1-x) ----------------
  logic [ONE_W-1:0]         rom_lo, rom_hi;
  logic                     s2_req_r, s2_neg_r, s2_clamp_r;
  logic [SH-1:0]            s2_frac_r;
  logic signed [PR_W-1:0]   s2_prod_r, s2_prod_nxt;

  sau_rom #(
    .FRAC_BITS     (FRAC_BITS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_rom (
    .clk    (clk),
    .rd_en  (adv2),
    .rd_idx (s1_idx_r),
    .rd_lo  (rom_lo),
    .rd_hi  (rom_hi)
  );

  assign s2_prod_nxt = PR_W'(s1_gx_r) * PR_W'(s1_om_r);

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_req_r   <= s1_req_r;
      s2_neg_r   <= s1_neg_r;
      s2_clamp_r <= s1_clamp_r;
      s2_frac_r  <= s1_frac_r;
      s2_prod_r  <= s2_prod_nxt;
    end
  end

  // ---------------- Stage 3: slope*frac, gradient magnitude ----------------
  logic [ONE_W-1:0]  slope;
  logic              b_neg;
  logic [PR_W-1:0]   b_abs;
  logic              s3_req_r, s3_neg_r, s3_clamp_r;
  logic              s3_neg_nxt;
  logic [ONE_W-1:0]  s3_lo_r;
  logic [DP_W-1:0]   s3_dp_r, s3_dp_nxt;
  logic [PR_W-1:0]   s3_mag_r, s3_mag_nxt;

  assign slope      = (rom_hi >= rom_lo) ? (rom_hi - rom_lo) : ONE_W'(0);
  assign s3_dp_nxt  = DP_W'(slope) * DP_W'(s2_frac_r);
  assign b_neg      = s2_prod_r[PR_W-1];
  assign b_abs      = b_neg ? (PR_W'(0) - s2_prod_r) : s2_prod_r;
  assign s3_mag_nxt = b_abs + RND_B;
  assign s3_neg_nxt = (s2_req_r == REQ_BWD) ? b_neg : s2_neg_r;

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_req_r   <= s2_req_r;
      s3_neg_r   <= s3_neg_nxt;
      s3_clamp_r <= s2_clamp_r;
      s3_lo_r    <= rom_lo;
      s3_dp_r    <= s3_dp_nxt;
      s3_mag_r   <= s3_mag_nxt;
    end
  end

  // ---------------- Stage 4: round, reflect, saturate ----------------
  logic [DP_W:0]     f_sum;
  logic [ONE_W:0]    f_inc;
  logic [ONE_W-1:0]  f_pos, f_mag, f_val;
  logic [SW-1:0]     f_ext;
  logic              f_sat;
  logic signed [15:0] f_res;
  logic [QX_W-1:0]   b_q;
  logic              b_sat;
  logic signed [15:0] b_res;
  logic              s4_req_r;
  sau_out_t          out_r, out_nxt;

  assign f_sum = (DP_W + 1)'(s3_dp_r) + HALF_SPAN;
  assign f_inc = f_sum[DP_W:SH];
  assign f_pos = ONE_W'((ONE_W + 1)'(s3_lo_r) + f_inc);
  assign f_mag = s3_clamp_r ? ONE_V : f_pos;
  assign f_val = s3_neg_r ? (ONE_V - f_mag) : f_mag;
  assign f_ext = SW'(f_val);
  assign f_sat = f_ext > FWD_MAX;
  assign f_res = f_sat ? RES_MAX : 16'(f_ext);

  assign b_q = QX_W'(s3_mag_r[PR_W-1:RSH]);

  always_comb begin
    if (s3_neg_r) begin
      b_sat = b_q > NEG_MAX;
      b_res = b_sat ? RES_MIN : 16'(QX_W'(0) - b_q);
    end else begin
      b_sat = b_q > POS_MAX;
      b_res = b_sat ? RES_MAX : 16'(b_q);
    end
  end

  always_comb begin
    if (s3_req_r == REQ_BWD) begin
      out_nxt.result    = b_res;
      out_nxt.saturated = b_sat;
    end else begin
      out_nxt.result    = f_res;
      out_nxt.saturated = f_sat;
    end
  end

  // Hold the output beat while stalled
  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_req_r <= s3_req_r;
      out_r    <= out_nxt;
    end
  end

  assign out_valid   = s4_v_r;
  assign out_payload = out_r;

  // ---------------- Assertions ----------------
  `SAU_ASSERT_NEXT(a_accept_fills_s1, in_valid && !in_stall, s1_v_r,
                   "accepted beat did not reach stage 1")
  `SAU_ASSERT_NOW(a_fwd_nonneg, out_valid && (s4_req_r == REQ_FWD),
                  out_payload.result >= 16'sd0, "forward result negative")
  `SAU_ASSERT_NOW(a_fwd_no_sat, out_valid && (s4_req_r == REQ_FWD) && (FRAC_BITS < 15),
                  !out_payload.saturated, "forward result saturated with narrow one")
  `SAU_ASSERT_NOW(a_bwd_sat_limit, out_valid && (s4_req_r == REQ_BWD) && out_payload.saturated,
                  (out_payload.result == RES_MAX) || (out_payload.result == RES_MIN),
                  "saturated gradient not at a limit")

endmodule
